/* sv/i2c_register_transaction_sequencer_defines.svh */
// Assertion macros for the I2C register transaction sequencer.
// Included by the top level, which holds the concurrent assertions.
`ifndef I2C_REGISTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_REGISTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CRTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("i2crts: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("i2crts: next-cycle check failed");

`endif

/* sv/i2crts_pkg.sv */
// Shared types and codes for the I2C register transaction sequencer.
// No dependencies; used by the core, the top level and the testbench.
`timescale 1ns / 1ps

package i2crts_pkg;

  // Kind of input item.
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_EVENT = 2'd2,
    REQ_ERROR = 2'd3
  } req_type_t;

  // Transaction phase.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_ADDR_W  = 4'd2,
    PH_REG     = 4'd3,
    PH_DATA    = 4'd4,
    PH_RESTART = 4'd5,
    PH_ADDR_R  = 4'd6,
    PH_RX      = 4'd7
  } phase_t;

  // Acknowledge control codes.
  localparam logic [1:0] ACK_KEEP = 2'd0;
  localparam logic [1:0] ACK_OFF  = 2'd1;
  localparam logic [1:0] ACK_ON   = 2'd2;

  // Interrupt control codes.
  localparam logic [1:0] IRQ_KEEP = 2'd0;
  localparam logic [1:0] IRQ_ON   = 2'd1;
  localparam logic [1:0] IRQ_OFF  = 2'd2;

  // Completion status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NACK = 2'd1;
  localparam logic [1:0] ST_BUS  = 2'd2;

  // One input item.
  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  dev_wr_addr;
    logic [7:0]  dev_rd_addr;
    logic [7:0]  reg_addr;
    logic [7:0]  write_data;
    logic        flag_start_sent;
    logic        flag_addr_done;
    logic        flag_tx_empty;
    logic        flag_byte_done;
    logic        flag_rx_ready;
    logic        flag_ack_fail;
    logic [7:0]  rx_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        drive_start;
    logic        drive_stop;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  ack_control;
    logic [1:0]  irq_control;
    logic        clear_addr_flag;
    logic        clear_errors;
    logic        done_res;
    logic [1:0]  status;
    logic        rx_valid;
    logic [7:0]  rx_data;
  } out_item_t;

  // Core status toward the top level.
  typedef struct packed {
    logic busy;
  } core_status_t;

endpackage

/* sv/i2crts_stream_if.sv */
// Valid/ready channel interface carrying one payload per transfer.
// The payload type is set per instance; used by the top level ports.
`timescale 1ns / 1ps

interface i2crts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/i2crts_core.sv */
// Phase state machine and saved transaction fields of the sequencer.
// Depends on i2crts_pkg; one item is processed on each cycle that step_en is high.
`timescale 1ns / 1ps

module i2crts_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  i2crts_pkg::in_item_t  item,
  output i2crts_pkg::out_item_t res,
  output i2crts_pkg::core_status_t stat
);
  import i2crts_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] wr_addr_r, wr_addr_nxt;
  logic [7:0] rd_addr_r, rd_addr_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [7:0] data_r, data_nxt;
  logic       read_mode_r, read_mode_nxt;

  // Next phase and saved fields.
  always_comb begin
    phase_nxt     = phase_r;
    wr_addr_nxt   = wr_addr_r;
    rd_addr_nxt   = rd_addr_r;
    reg_nxt       = reg_r;
    data_nxt      = data_r;
    read_mode_nxt = read_mode_r;
    case (item.req_type)
      REQ_WRITE, REQ_READ: begin
        if (phase_r == PH_IDLE) begin
          wr_addr_nxt = item.dev_wr_addr;
          reg_nxt     = item.reg_addr;
          if (item.req_type == REQ_READ) begin
            rd_addr_nxt   = item.dev_rd_addr;
            read_mode_nxt = 1'b1;
          end else begin
            data_nxt      = item.write_data;
            read_mode_nxt = 1'b0;
          end
          phase_nxt = PH_START;
        end
      end
      REQ_EVENT: begin
        case (phase_r)
          PH_START:   if (item.flag_start_sent) phase_nxt = PH_ADDR_W;
          PH_ADDR_W:  if (item.flag_addr_done) phase_nxt = PH_REG;
          PH_REG:     if (item.flag_tx_empty) phase_nxt = read_mode_r ? PH_RESTART : PH_DATA;
          PH_DATA:    if (item.flag_byte_done) phase_nxt = PH_IDLE;
          PH_RESTART: if (item.flag_start_sent) phase_nxt = PH_ADDR_R;
          PH_ADDR_R:  if (item.flag_addr_done) phase_nxt = PH_RX;
          PH_RX:      if (item.flag_rx_ready) phase_nxt = PH_IDLE;
          default:    phase_nxt = phase_r;
        endcase
      end
      REQ_ERROR: begin
        phase_nxt = PH_IDLE;
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Result fields for the current item; everything not named stays zero.
  always_comb begin
    res = '0;
    case (item.req_type)
      REQ_WRITE, REQ_READ: begin
        if (phase_r == PH_IDLE) begin
          res.irq_control = IRQ_ON;
          res.drive_start = 1'b1;
        end
      end
      REQ_EVENT: begin
        case (phase_r)
          PH_START: begin
            if (item.flag_start_sent) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = wr_addr_r;
            end
          end
          PH_ADDR_W: begin
            if (item.flag_addr_done) begin
              res.clear_addr_flag = 1'b1;
              res.tx_valid        = 1'b1;
              res.tx_byte         = reg_r;
            end
          end
          PH_REG: begin
            if (item.flag_tx_empty) begin
              if (read_mode_r) begin
                res.drive_start = 1'b1;
              end else begin
                res.tx_valid = 1'b1;
                res.tx_byte  = data_r;
              end
            end
          end
          PH_DATA: begin
            if (item.flag_byte_done) begin
              res.irq_control = IRQ_OFF;
              res.drive_stop  = 1'b1;
              res.done_res    = 1'b1;
            end
          end
          PH_RESTART: begin
            if (item.flag_start_sent) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = rd_addr_r;
            end
          end
          PH_ADDR_R: begin
            if (item.flag_addr_done) begin
              res.ack_control     = ACK_OFF;
              res.clear_addr_flag = 1'b1;
              res.drive_stop      = 1'b1;
            end
          end
          PH_RX: begin
            if (item.flag_rx_ready) begin
              res.rx_valid    = 1'b1;
              res.rx_data     = item.rx_byte;
              res.ack_control = ACK_ON;
              res.irq_control = IRQ_OFF;
              res.done_res    = 1'b1;
            end
          end
          default: res = '0;
        endcase
      end
      REQ_ERROR: begin
        if (phase_r != PH_IDLE) begin
          res.clear_errors = 1'b1;
          res.irq_control  = IRQ_OFF;
          res.drive_stop   = 1'b1;
          res.done_res     = 1'b1;
          res.status       = item.flag_ack_fail ? ST_NACK : ST_BUS;
        end
      end
      default: res = '0;
    endcase
  end

  assign stat.busy = (phase_r != PH_IDLE);

  // State registers advance only when an item is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      wr_addr_r   <= '0;
      rd_addr_r   <= '0;
      reg_r       <= '0;
      data_r      <= '0;
      read_mode_r <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      wr_addr_r   <= wr_addr_nxt;
      rd_addr_r   <= rd_addr_nxt;
      reg_r       <= reg_nxt;
      data_r      <= data_nxt;
      read_mode_r <= read_mode_nxt;
    end
  end

endmodule

/* sv/i2c_register_transaction_sequencer.sv */
// Top level of the I2C register transaction sequencer: input register,
// core state machine and result register. Depends on i2crts_pkg,
// i2crts_stream_if, i2crts_core and the assertion macro header.
//
//   Channel   Direction  Payload      Transfer when
//   in_chan   sink       in_item_t    in_chan.valid && in_chan.ready
//   out_chan  source     out_item_t   out_chan.valid && out_chan.ready
//
// Each item yields exactly one result, through the input register and the
// result register; one item per cycle is sustained while the output is not stalled.
// Only the core's phase register and saved fields persist across items; each updates once per item.
// Reset is synchronous and active low; it empties both stages and returns
// the phase to idle.
// A stalled output holds its result; the input stage keeps filling until it
// also holds an item, then in_chan.ready drops.
`timescale 1ns / 1ps
`include "i2c_register_transaction_sequencer_defines.svh"

module i2c_register_transaction_sequencer (
  input  logic                   clk,
  input  logic                   rst_n,
  i2crts_stream_if.sink          in_chan,
  i2crts_stream_if.source        out_chan
);
  import i2crts_pkg::*;

  logic         in_valid_r, in_valid_nxt;
  in_item_t     in_data_r;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_data_r;
  out_item_t    core_res;
  core_status_t core_stat;
  logic         out_load;
  logic         step_en;
  logic         in_xfer;

  // Handshake: the result register frees when empty or being drained.
  assign out_load       = !out_valid_r || out_chan.ready;
  assign step_en        = in_valid_r && out_load;
  assign in_chan.ready  = !in_valid_r || out_load;
  assign in_xfer        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_comb begin
    in_valid_nxt  = in_xfer ? 1'b1 : (step_en ? 1'b0 : in_valid_r);
    out_valid_nxt = step_en ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_data_r <= in_chan.data;
    end
    if (step_en) begin
      out_data_r <= core_res;
    end
  end

  i2crts_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_data_r),
    .res     (core_res),
    .stat    (core_stat)
  );

  // A finished transaction leaves the core idle.
  `I2CRTS_ASSERT_NEXT(a_done_idle, clk, rst_n, step_en && core_res.done_res, !core_stat.busy)
  // A START that enables interrupts opens a transaction.
  `I2CRTS_ASSERT_NEXT(a_req_busy, clk, rst_n, step_en && core_res.drive_start && (core_res.irq_control == IRQ_ON), core_stat.busy)
  // A failure status or a received byte only comes with completion.
  `I2CRTS_ASSERT_SAME(a_status_done, clk, rst_n, (core_res.status != ST_OK) || core_res.rx_valid, core_res.done_res)
  // Nothing is accepted while both stages are full and the output stalls.
  `I2CRTS_ASSERT_SAME(a_full_stall, clk, rst_n, in_valid_r && out_valid_r && !out_chan.ready, !in_chan.ready)

endmodule

/* sim/i2c_register_transaction_sequencer_tb.sv */
// Self-checking testbench for the I2C register transaction sequencer.
// A scoreboard predicts every result. Directed and random transactions drive
// the block through i2crts_stream_if. Depends on i2crts_pkg and the RTL.
`timescale 1ns / 1ps

module i2c_register_transaction_sequencer_tb;
  import i2crts_pkg::*;

  // One-hot masks over the five status flags of an event.
  localparam logic [4:0] F_START     = 5'b00001;
  localparam logic [4:0] F_ADDR      = 5'b00010;
  localparam logic [4:0] F_TX_EMPTY  = 5'b00100;
  localparam logic [4:0] F_BYTE_DONE = 5'b01000;
  localparam logic [4:0] F_RX_READY  = 5'b10000;
  localparam logic [4:0] F_ALL       = 5'b11111;

  localparam int RANDOM_TARGET = 1700;
  localparam int HOLD_CYCLES   = 120;

  // Predicts the bus actions of the sequencer and checks the results.
  class i2c_seq_scoreboard;
    phase_t     phase;
    logic [7:0] wr_addr;
    logic [7:0] rd_addr;
    logic [7:0] reg_num;
    logic [7:0] data_byte;
    logic       reading;
    out_item_t  expected_actions[$];
    int         errors;
    int         advanced;
    int         ignored;
    int         results_seen;
    int         writes_ok;
    int         reads_ok;
    int         nacks;
    int         bus_errors;

    function new();
      phase        = PH_IDLE;
      wr_addr      = '0;
      rd_addr      = '0;
      reg_num      = '0;
      data_byte    = '0;
      reading      = 1'b0;
      errors       = 0;
      advanced     = 0;
      ignored      = 0;
      results_seen = 0;
      writes_ok    = 0;
      reads_ok     = 0;
      nacks        = 0;
      bus_errors   = 0;
    endfunction

    // Handles the status event of an active transaction; only the flag
    // that the current phase waits for is looked at.
    function out_item_t advance_on_event(in_item_t it);
      out_item_t r;
      r = '0;
      case (phase)
        PH_START: if (it.flag_start_sent) begin
          phase = PH_ADDR_W;
          r.tx_valid = 1'b1;
          r.tx_byte = wr_addr;
        end
        PH_ADDR_W: if (it.flag_addr_done) begin
          phase = PH_REG;
          r.clear_addr_flag = 1'b1;
          r.tx_valid = 1'b1;
          r.tx_byte = reg_num;
        end
        PH_REG: if (it.flag_tx_empty) begin
          if (reading) begin
            phase = PH_RESTART;
            r.drive_start = 1'b1;
          end else begin
            phase = PH_DATA;
            r.tx_valid = 1'b1;
            r.tx_byte = data_byte;
          end
        end
        PH_DATA: if (it.flag_byte_done) begin
          phase = PH_IDLE;
          r.irq_control = IRQ_OFF;
          r.drive_stop = 1'b1;
          r.done_res = 1'b1;
          r.status = ST_OK;
          writes_ok++;
        end
        PH_RESTART: if (it.flag_start_sent) begin
          phase = PH_ADDR_R;
          r.tx_valid = 1'b1;
          r.tx_byte = rd_addr;
        end
        PH_ADDR_R: if (it.flag_addr_done) begin
          phase = PH_RX;
          r.ack_control = ACK_OFF;
          r.clear_addr_flag = 1'b1;
          r.drive_stop = 1'b1;
        end
        PH_RX: if (it.flag_rx_ready) begin
          phase = PH_IDLE;
          r.rx_valid = 1'b1;
          r.rx_data = it.rx_byte;
          r.ack_control = ACK_ON;
          r.irq_control = IRQ_OFF;
          r.done_res = 1'b1;
          r.status = ST_OK;
          reads_ok++;
        end
        default: ;
      endcase
      return r;
    endfunction

    // Works out the bus actions for one accepted item and updates the state.
    function out_item_t next_bus_actions(in_item_t it);
      out_item_t r;
      r = '0;
      case (it.req_type)
        REQ_WRITE, REQ_READ: if (phase == PH_IDLE) begin
          wr_addr = it.dev_wr_addr;
          reg_num = it.reg_addr;
          if (it.req_type == REQ_READ) begin
            rd_addr = it.dev_rd_addr;
            reading = 1'b1;
          end else begin
            data_byte = it.write_data;
            reading = 1'b0;
          end
          phase = PH_START;
          r.irq_control = IRQ_ON;
          r.drive_start = 1'b1;
        end
        REQ_EVENT: if (phase != PH_IDLE) begin
          r = advance_on_event(it);
        end
        default: if (phase != PH_IDLE) begin
          phase = PH_IDLE;
          r.clear_errors = 1'b1;
          r.irq_control = IRQ_OFF;
          r.drive_stop = 1'b1;
          r.done_res = 1'b1;
          r.status = it.flag_ack_fail ? ST_NACK : ST_BUS;
          if (it.flag_ack_fail) nacks++;
          else bus_errors++;
        end
      endcase
      return r;
    endfunction

    // Called for every input transfer.
    function void note_item(in_item_t it);
      out_item_t r;
      r = next_bus_actions(it);
      if (r != '0) advanced++;
      else ignored++;
      expected_actions.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      end
    endfunction

    // Called for every result transfer; compares against the oldest prediction.
    function void check_actions(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_actions.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_actions.pop_front();
      compare_field("drive_start", 8'(want.drive_start), 8'(got.drive_start));
      compare_field("drive_stop", 8'(want.drive_stop), 8'(got.drive_stop));
      compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("ack_control", 8'(want.ack_control), 8'(got.ack_control));
      compare_field("irq_control", 8'(want.irq_control), 8'(got.irq_control));
      compare_field("clear_addr_flag", 8'(want.clear_addr_flag), 8'(got.clear_addr_flag));
      compare_field("clear_errors", 8'(want.clear_errors), 8'(got.clear_errors));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
      compare_field("rx_data", want.rx_data, got.rx_data);
    endfunction

    function int outstanding();
      return expected_actions.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_request;
  i2c_seq_scoreboard board;

  i2crts_stream_if #(.payload_t(in_item_t))  in_chan ();
  i2crts_stream_if #(.payload_t(out_item_t)) out_chan ();

  i2c_register_transaction_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every result transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) board.check_actions(out_chan.data);
  end

  // Flag that the given phase waits for.
  function automatic logic [4:0] awaited_flag(phase_t p);
    case (p)
      PH_START, PH_RESTART: return F_START;
      PH_ADDR_W, PH_ADDR_R: return F_ADDR;
      PH_REG:               return F_TX_EMPTY;
      PH_DATA:              return F_BYTE_DONE;
      default:              return F_RX_READY;
    endcase
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  // Offers one item after a random gap and waits for its transfer.
  // Entered and left at a falling edge.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_item(it);
    @(negedge clk);
  endtask

  task automatic send_request(input req_type_t kind, input logic [7:0] wa, input logic [7:0] ra,
                              input logic [7:0] rg, input logic [7:0] wd);
    in_item_t it;
    it = random_item();
    it.req_type    = kind;
    it.dev_wr_addr = wa;
    it.dev_rd_addr = ra;
    it.reg_addr    = rg;
    it.write_data  = wd;
    send_item(it);
  endtask

  task automatic send_event(input logic [4:0] flags, input logic [7:0] rx);
    in_item_t it;
    it = random_item();
    it.req_type        = REQ_EVENT;
    it.flag_start_sent = flags[0];
    it.flag_addr_done  = flags[1];
    it.flag_tx_empty   = flags[2];
    it.flag_byte_done  = flags[3];
    it.flag_rx_ready   = flags[4];
    it.rx_byte         = rx;
    send_item(it);
  endtask

  task automatic send_error(input logic ack_fail);
    in_item_t it;
    it = random_item();
    it.req_type      = REQ_ERROR;
    it.flag_ack_fail = ack_fail;
    send_item(it);
  endtask

  // Mostly well-formed transactions with random content; the rest are
  // aborts, wrong flags, requests while busy and events while idle.
  task automatic run_random(input int target);
    int pick;
    logic [4:0] want;
    while (board.advanced + board.ignored < target) begin
      pick = $urandom_range(99);
      if (board.phase == PH_IDLE) begin
        if (pick < 88) begin
          send_request(pick[0] ? REQ_READ : REQ_WRITE, 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
        end else if (pick < 94) begin
          send_event(5'($urandom), 8'($urandom));
        end else begin
          send_error(1'($urandom_range(1)));
        end
      end else begin
        want = awaited_flag(board.phase);
        if (pick < 80) begin
          send_event(5'($urandom) | want, 8'($urandom));
        end else if (pick < 86) begin
          send_error(1'($urandom_range(1)));
        end else if (pick < 93) begin
          send_event(5'($urandom) & ~want, 8'($urandom));
        end else begin
          send_request(req_type_t'($urandom_range(1)), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  // Run limit.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int waited;
    board = new();
    rst_n = 1'b0;
    hold_request = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    send_idle_pct = 37;
    recv_idle_pct = 71;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // An event and an error while idle are ignored.
    send_event(F_ALL, 8'hFF);
    send_error(1'b1);
    // Write with extreme fields, a request while busy and wrong flags.
    send_request(REQ_WRITE, 8'hFF, 8'h00, 8'h00, 8'hFF);
    send_request(REQ_READ, 8'h12, 8'h34, 8'h56, 8'h78);
    send_event(F_ALL & ~F_START, 8'h00);
    send_event(F_START, 8'h00);
    send_event(F_ADDR, 8'h00);
    send_event(F_TX_EMPTY, 8'h00);
    send_event(F_ALL & ~F_BYTE_DONE, 8'hFF);
    send_event(F_BYTE_DONE, 8'h00);
    // Full read with a wrong flag while waiting for the received byte.
    send_request(REQ_READ, 8'h00, 8'hFF, 8'hFF, 8'h00);
    send_event(F_START, 8'h00);
    send_event(F_ADDR, 8'h00);
    send_event(F_TX_EMPTY, 8'h00);
    send_event(F_START, 8'h00);
    send_event(F_ADDR, 8'h00);
    send_event(F_ALL & ~F_RX_READY, 8'h00);
    send_event(F_RX_READY, 8'hFF);
    // Aborts: acknowledge failure on a read, bus error on a write.
    send_request(REQ_READ, 8'hA5, 8'h5A, 8'h3C, 8'hC3);
    send_event(F_START, 8'h00);
    send_error(1'b1);
    send_request(REQ_WRITE, 8'h5A, 8'hA5, 8'hC3, 8'h3C);
    send_event(F_START, 8'h00);
    send_event(F_ADDR, 8'h00);
    send_error(1'b0);

    // Random part under three stall patterns, each opened by a long hold-off.
    hold_request = 1'b1;
    run_random(RANDOM_TARGET / 3);
    send_idle_pct = 71;
    recv_idle_pct = 37;
    hold_request = 1'b1;
    run_random(2 * RANDOM_TARGET / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    run_random(RANDOM_TARGET);
    in_chan.valid <= 1'b0;

    // Drain, then allow a few more cycles for anything stray.
    waited = 0;
    while (board.outstanding() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (board.outstanding() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, board.outstanding());
    end

    $display("Checked %0d results; %0d items moved the sequencer on, %0d were ignored.",
             board.results_seen, board.advanced, board.ignored);
    $display("Completed %0d writes and %0d reads; aborted %0d with NACK and %0d with bus error.",
             board.writes_ok, board.reads_ok, board.nacks, board.bus_errors);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
